FILE: rtl/core/linear_regression_sgd_step_unit_macros.svh
// Assertion macros shared by the linear regression SGD step unit RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef LINEAR_REGRESSION_SGD_STEP_UNIT_MACROS_SVH
`define LINEAR_REGRESSION_SGD_STEP_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define LRSGD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
`define LRSGD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define LRSGD_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define LRSGD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/core/lrsgd_pkg.sv
// Package for the linear regression SGD step unit: request codes, fixed
// widths, control struct and saturation helpers. No dependencies.
`default_nettype none

package lrsgd_pkg;

    localparam int FEAT_W = 16;
    localparam int WGT_W  = 32;
    localparam int ACC_W  = 48;
    localparam int LR_W   = 16;
    localparam int WIDE_W = 49;
    localparam int MUL_A_W = 34;
    localparam int MUL_B_W = 18;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    localparam logic [1:0] REQ_TRAIN   = 2'd0;
    localparam logic [1:0] REQ_PREDICT = 2'd1;
    localparam logic [1:0] REQ_CLEAR   = 2'd2;

    localparam logic [LR_W-1:0] LR_RESET = 16'd655;

    typedef struct packed {
        logic clr;
        logic wr;
        logic rd;
    } t_wst_ctl;

    function automatic logic [WGT_W-1:0] sat32(input logic [WIDE_W-1:0] v);
        logic [WIDE_W-1:0] hi;
        logic [WIDE_W-1:0] lo;
        hi = {{(WIDE_W-WGT_W+1){1'b0}}, {(WGT_W-1){1'b1}}};
        lo = ~hi;
        if ($signed(v) > $signed(hi)) begin
            sat32 = hi[WGT_W-1:0];
        end else if ($signed(v) < $signed(lo)) begin
            sat32 = lo[WGT_W-1:0];
        end else begin
            sat32 = v[WGT_W-1:0];
        end
    endfunction

    function automatic logic [ACC_W-1:0] sat48(input logic [WIDE_W-1:0] v);
        if (v[WIDE_W-1] != v[WIDE_W-2]) begin
            sat48 = v[WIDE_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end else begin
            sat48 = v[ACC_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/lrsgd_mul.sv
// Shared signed multiplier with registered product.
// Depends on lrsgd_pkg.
`default_nettype none

module lrsgd_mul
    import lrsgd_pkg::*;
(
    input  wire                 i_clk,
    input  wire                 i_en,
    input  wire [MUL_A_W-1:0]   i_a,
    input  wire [MUL_B_W-1:0]   i_b,
    output logic [MUL_P_W-1:0]  o_p
);

    logic [MUL_P_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= $signed({{(MUL_P_W-MUL_A_W){i_a[MUL_A_W-1]}}, i_a})
                 * $signed({{(MUL_P_W-MUL_B_W){i_b[MUL_B_W-1]}}, i_b});
        end
    end

    assign o_p = r_p;

endmodule

`default_nettype wire

FILE: rtl/core/lrsgd_wstore.sv
// Weight store: single-port memory with per-entry valid bits, registered read.
// Depends on lrsgd_pkg. Invalid entries read as zero.
`default_nettype none

module lrsgd_wstore
    import lrsgd_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int IDX_W = 4
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  t_wst_ctl          i_ctl,
    input  wire [IDX_W-1:0]   i_addr,
    input  wire [WGT_W-1:0]   i_wdata,
    output logic [WGT_W-1:0]  o_rdata
);

    logic [WGT_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0] r_vld;
    logic [DEPTH-1:0] n_vld;
    logic [WGT_W-1:0] r_rd;
    logic             r_rd_vld;

    always_comb begin
        n_vld = r_vld;
        if (i_ctl.clr) begin
            n_vld = '0;
        end else if (i_ctl.wr) begin
            n_vld[i_addr] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
            if (i_ctl.rd) begin
                r_rd_vld <= r_vld[i_addr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_ctl.rd) begin
            r_rd <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rd_vld ? r_rd : '0;

endmodule

`default_nettype wire

FILE: rtl/core/linear_regression_sgd_step_unit.sv
// Top level of the linear regression SGD step unit: sequencer, feature buffer.
// Depends on lrsgd_pkg, lrsgd_mul, lrsgd_wstore and the assertion macro header.
//
//   channel | valid       | ready        | payload
//   --------+-------------+--------------+---------------------------------------------
//   in      | i_in_valid  | o_in_ready   | i_req_type i_feature_value i_feature_last i_target
//   out     | o_out_valid | i_out_ready  | o_prediction o_error o_was_trained
//   cfg     | i_cfg_valid | o_cfg_ready  | i_cfg_learning_rate
//
// A feature word goes through weight read, multiply and accumulate; a last word adds
// prediction, error and output load. Training adds the step, then a weight read, multiply
// and write per stored feature, all through the one shared multiplier and weight port.
// Reset is synchronous and clears weights (valid bits), bias, count and accumulator.
// A pending output word stalls the next result only; input is taken again when idle.
`default_nettype none

`include "linear_regression_sgd_step_unit_macros.svh"

module linear_regression_sgd_step_unit
    import lrsgd_pkg::*;
#(
    parameter int MAX_FEATURES = 16
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    output logic               o_in_ready,
    input  wire [1:0]          i_req_type,
    input  wire [FEAT_W-1:0]   i_feature_value,
    input  wire                i_feature_last,
    input  wire [FEAT_W-1:0]   i_target,
    output logic               o_out_valid,
    input  wire                i_out_ready,
    output logic [WGT_W-1:0]   o_prediction,
    output logic [WGT_W-1:0]   o_error,
    output logic               o_was_trained,
    input  wire                i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire [LR_W-1:0]     i_cfg_learning_rate
);

    localparam int IDX_W = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
    localparam int CNT_W = $clog2(MAX_FEATURES + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_FEATURES);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_MAC_MUL  = 4'd1;
    localparam logic [3:0] S_MAC_ACC  = 4'd2;
    localparam logic [3:0] S_PRED     = 4'd3;
    localparam logic [3:0] S_ERR      = 4'd4;
    localparam logic [3:0] S_OUT      = 4'd5;
    localparam logic [3:0] S_STEP_MUL = 4'd6;
    localparam logic [3:0] S_STEP     = 4'd7;
    localparam logic [3:0] S_UPD_RD   = 4'd8;
    localparam logic [3:0] S_UPD_MUL  = 4'd9;
    localparam logic [3:0] S_UPD_WR   = 4'd10;

    logic [3:0]          r_state, n_state;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [IDX_W-1:0]    r_idx, n_idx;
    logic [ACC_W-1:0]    r_acc, n_acc;
    logic [WGT_W-1:0]    r_bias, n_bias;
    logic [LR_W-1:0]     r_lr;
    logic [1:0]          r_req;
    logic                r_last;
    logic [FEAT_W-1:0]   r_x;
    logic [FEAT_W-1:0]   r_tgt;
    logic [WGT_W-1:0]    r_pred;
    logic [WGT_W-1:0]    r_err;
    logic [MUL_A_W-1:0]  r_step;
    logic [FEAT_W-1:0]   r_fbuf [MAX_FEATURES];
    logic [FEAT_W-1:0]   r_fb_rd;
    logic                r_out_valid;
    logic [WGT_W-1:0]    r_out_pred;
    logic [WGT_W-1:0]    r_out_err;
    logic                r_out_trained;

    logic                in_acc;
    logic                out_free;
    logic                fb_wr;
    logic                cnt_full;
    t_wst_ctl            wst_ctl;
    logic [IDX_W-1:0]    wst_addr;
    logic [WGT_W-1:0]    wst_wdata;
    logic [WGT_W-1:0]    wst_rdata;
    logic                mul_en;
    logic [MUL_A_W-1:0]  mul_a;
    logic [MUL_B_W-1:0]  mul_b;
    logic [MUL_P_W-1:0]  mul_p;
    logic [MUL_A_W-1:0]  step_c;
    logic [WIDE_W-1:0]   acc_sum;
    logic [WIDE_W-1:0]   pred_sum;
    logic [WIDE_W-1:0]   err_sum;
    logic [WIDE_W-1:0]   bias_sum;
    logic [WIDE_W-1:0]   wgt_sum;
    logic [CNT_W-1:0]    idx_next;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign cnt_full    = (r_cnt == CNT_MAX);
    assign fb_wr       = in_acc && (i_req_type != REQ_CLEAR) && !cnt_full;
    assign idx_next    = CNT_W'(r_idx) + CNT_W'(1);

    // product >>> 8 for w*x and step*x, product >>> 16 for 2*lr*err
    assign step_c   = mul_p[MUL_A_W+15:16];
    assign acc_sum  = {{(WIDE_W-MUL_P_W+8){mul_p[MUL_P_W-1]}}, mul_p[MUL_P_W-1:8]}
                    + {r_acc[ACC_W-1], r_acc};
    assign pred_sum = {{(WIDE_W-WGT_W){r_bias[WGT_W-1]}}, r_bias}
                    + {r_acc[ACC_W-1], r_acc};
    assign err_sum  = {{(WIDE_W-WGT_W){r_pred[WGT_W-1]}}, r_pred}
                    - {{(WIDE_W-FEAT_W-8){r_tgt[FEAT_W-1]}}, r_tgt, 8'd0};
    assign bias_sum = {{(WIDE_W-WGT_W){r_bias[WGT_W-1]}}, r_bias}
                    - {{(WIDE_W-MUL_A_W){step_c[MUL_A_W-1]}}, step_c};
    assign wgt_sum  = {{(WIDE_W-WGT_W){wst_rdata[WGT_W-1]}}, wst_rdata}
                    - {{(WIDE_W-MUL_P_W+8){mul_p[MUL_P_W-1]}}, mul_p[MUL_P_W-1:8]};

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_idx       = r_idx;
        n_acc       = r_acc;
        n_bias      = r_bias;
        wst_ctl     = '0;
        wst_addr    = r_idx;
        wst_wdata   = sat32(wgt_sum);
        mul_en      = 1'b0;
        mul_a       = {{(MUL_A_W-WGT_W){wst_rdata[WGT_W-1]}}, wst_rdata};
        mul_b       = {{(MUL_B_W-FEAT_W){r_x[FEAT_W-1]}}, r_x};
        unique case (r_state)
            S_IDLE: begin
                wst_addr = r_cnt[IDX_W-1:0];
                if (in_acc) begin
                    if (i_req_type == REQ_CLEAR) begin
                        wst_ctl.clr = 1'b1;
                        n_bias      = '0;
                        n_cnt       = '0;
                        n_acc       = '0;
                    end else if (!cnt_full) begin
                        wst_ctl.rd = 1'b1;
                        n_state    = S_MAC_MUL;
                    end else if (i_feature_last) begin
                        n_state = S_PRED;
                    end
                end
            end
            S_MAC_MUL: begin
                mul_en  = 1'b1;
                n_state = S_MAC_ACC;
            end
            S_MAC_ACC: begin
                n_acc   = sat48(acc_sum);
                n_cnt   = r_cnt + CNT_W'(1);
                n_state = r_last ? S_PRED : S_IDLE;
            end
            S_PRED: begin
                n_state = S_ERR;
            end
            S_ERR: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    if (r_req == REQ_TRAIN) begin
                        n_state = S_STEP_MUL;
                    end else begin
                        n_cnt   = '0;
                        n_acc   = '0;
                        n_state = S_IDLE;
                    end
                end
            end
            S_STEP_MUL: begin
                mul_en  = 1'b1;
                mul_a   = {{(MUL_A_W-WGT_W){r_err[WGT_W-1]}}, r_err};
                mul_b   = {1'b0, r_lr, 1'b0};
                n_state = S_STEP;
            end
            S_STEP: begin
                n_bias  = sat32(bias_sum);
                n_idx   = '0;
                n_state = S_UPD_RD;
            end
            S_UPD_RD: begin
                wst_ctl.rd = 1'b1;
                n_state    = S_UPD_MUL;
            end
            S_UPD_MUL: begin
                mul_en  = 1'b1;
                mul_a   = r_step;
                mul_b   = {{(MUL_B_W-FEAT_W){r_fb_rd[FEAT_W-1]}}, r_fb_rd};
                n_state = S_UPD_WR;
            end
            S_UPD_WR: begin
                wst_ctl.wr = 1'b1;
                if (idx_next == r_cnt) begin
                    n_cnt   = '0;
                    n_acc   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_idx   = idx_next[IDX_W-1:0];
                    n_state = S_UPD_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_idx       <= '0;
            r_acc       <= '0;
            r_bias      <= '0;
            r_lr        <= LR_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_idx   <= n_idx;
            r_acc   <= n_acc;
            r_bias  <= n_bias;
            if (i_cfg_valid) begin
                r_lr <= i_cfg_learning_rate;
            end
            if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_req  <= i_req_type;
            r_last <= i_feature_last;
            r_x    <= i_feature_value;
            r_tgt  <= i_target;
        end
        if (fb_wr) begin
            r_fbuf[r_cnt[IDX_W-1:0]] <= i_feature_value;
        end
        if (r_state == S_UPD_RD) begin
            r_fb_rd <= r_fbuf[r_idx];
        end
        if (r_state == S_PRED) begin
            r_pred <= sat32(pred_sum);
        end
        if (r_state == S_ERR) begin
            r_err <= sat32(err_sum);
        end
        if (r_state == S_STEP) begin
            r_step <= step_c;
        end
        if (r_state == S_OUT && out_free) begin
            r_out_pred    <= r_pred;
            r_out_err     <= r_err;
            r_out_trained <= (r_req == REQ_TRAIN);
        end
    end

    lrsgd_mul u_mul (
        .i_clk (i_clk),
        .i_en  (mul_en),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    lrsgd_wstore #(
        .DEPTH (MAX_FEATURES),
        .IDX_W (IDX_W)
    ) u_wstore (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (wst_ctl),
        .i_addr  (wst_addr),
        .i_wdata (wst_wdata),
        .o_rdata (wst_rdata)
    );

    assign o_out_valid   = r_out_valid;
    assign o_prediction  = r_out_pred;
    assign o_error       = r_out_err;
    assign o_was_trained = r_out_trained;

    `LRSGD_ASSERT_SAME(a_cnt_bound, i_clk, i_rst_n, 1'b1, r_cnt <= CNT_MAX)
    `LRSGD_ASSERT_SAME(a_upd_idx, i_clk, i_rst_n, r_state == S_UPD_WR, idx_next <= r_cnt)
    `LRSGD_ASSERT_NEXT(a_clear, i_clk, i_rst_n, in_acc && i_req_type == REQ_CLEAR,
        r_bias == '0 && r_cnt == '0 && r_acc == '0)
    `LRSGD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n,
        r_state == S_OUT && r_out_valid && !i_out_ready, r_state == S_OUT)

endmodule

`default_nettype wire
